### hw/rtl/dntp_pkg.sv
// Shared types and constants for the decimal number text parser.
// Byte classes, queue entry, control encodings and field widths.
// No dependencies.
`default_nettype none

package dntp_pkg;

  localparam int unsigned MantW  = 60;
  localparam int unsigned ExpW   = 16;
  localparam int unsigned EvW    = 15;
  localparam int unsigned FcW    = 16;
  localparam int unsigned SigW   = 5;
  localparam int unsigned CountW = 12;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChLowE  = 8'h65;
  localparam logic [7:0] ChLowD  = 8'h64;
  localparam logic [7:0] ChUpE   = 8'h45;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef enum logic [2:0] {
    CL_DIGIT = 3'd0,
    CL_DOT   = 3'd1,
    CL_MINUS = 3'd2,
    CL_PLUS  = 3'd3,
    CL_EXP   = 3'd4,
    CL_SPACE = 3'd5,
    CL_NUL   = 3'd6,
    CL_OTHER = 3'd7
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [3:0] digit;
  } entry_t;

  typedef enum logic [2:0] {
    MODE_SEEK  = 3'b001,
    MODE_PEND  = 3'b010,
    MODE_PARSE = 3'b100
  } mode_e;

  typedef enum logic [3:0] {
    PH_INT  = 4'b0001,
    PH_FRAC = 4'b0010,
    PH_EPOS = 4'b0100,
    PH_ENEG = 4'b1000
  } phase_e;

endpackage

`default_nettype wire

### hw/rtl/dntp_front.sv
// Front end: takes text bytes and classifies each into a queue entry.
// Depends on dntp_pkg.
`default_nettype none

module dntp_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        text_byte_i,
  input  logic              q_full_i,
  output logic              push_o,
  output dntp_pkg::entry_t  entry_o
);
  import dntp_pkg::*;

  logic [7:0] digit_off;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;
  assign digit_off  = text_byte_i - ChZero;

  always_comb begin
    entry_o.digit = digit_off[3:0];
    if (text_byte_i >= ChZero && text_byte_i <= ChNine) begin
      entry_o.cls = CL_DIGIT;
    end else if (text_byte_i == ChDot) begin
      entry_o.cls = CL_DOT;
    end else if (text_byte_i == ChMinus) begin
      entry_o.cls = CL_MINUS;
    end else if (text_byte_i == ChPlus) begin
      entry_o.cls = CL_PLUS;
    end else if (text_byte_i == ChLowE || text_byte_i == ChLowD || text_byte_i == ChUpE) begin
      entry_o.cls = CL_EXP;
    end else if (text_byte_i == ChSpace || text_byte_i == ChTab || text_byte_i == ChNl) begin
      entry_o.cls = CL_SPACE;
    end else if (text_byte_i == ChNul) begin
      entry_o.cls = CL_NUL;
    end else begin
      entry_o.cls = CL_OTHER;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dntp_queue.sv
// Short queue of classified bytes between front and back end.
// Depends on dntp_pkg.
`default_nettype none

module dntp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dntp_pkg::entry_t  push_entry_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              not_empty_o,
  output dntp_pkg::entry_t  head_o
);
  import dntp_pkg::*;

  entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   count_q, count_d;
  logic               do_pop;

  assign full_o      = (count_q == QCntW'(QDepth));
  assign not_empty_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  assign do_pop      = pop_i & not_empty_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dntp_back.sv
// Back end: number parsing state machine and output register.
// Consumes classified bytes from dntp_queue; depends on dntp_pkg.
`default_nettype none

module dntp_back #(
  parameter int unsigned MAX_DIGITS = 18,
  parameter int unsigned EXP_LIMIT  = 9999
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_not_empty_i,
  input  dntp_pkg::entry_t                  head_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              status_o,
  output logic                              is_negative_o,
  output logic [dntp_pkg::MantW-1:0]        mantissa_o,
  output logic signed [dntp_pkg::ExpW-1:0]  decimal_exponent_o,
  output logic                              digits_dropped_o,
  output logic [dntp_pkg::CountW-1:0]       chars_used_o
);
  import dntp_pkg::*;

  localparam logic signed [19:0] EvMax = 20'(EXP_LIMIT);
  localparam logic signed [19:0] EvMin = -20'(EXP_LIMIT);
  localparam logic signed [FcW-1:0] FcMax = 16'sd32767;
  localparam logic signed [FcW-1:0] FcMin = -16'sd32767;
  localparam logic signed [16:0] EoMax = 17'sd32767;
  localparam logic signed [16:0] EoMin = -17'sd32767;

  mode_e                   mode_q, mode_d;
  cls_e                    pend_q, pend_d;
  phase_e                  phase_q, phase_d;
  logic                    sign_q, sign_d;
  logic [MantW-1:0]        acc_q, acc_d;
  logic [SigW-1:0]         sig_q, sig_d;
  logic signed [FcW-1:0]   fc_q, fc_d;
  logic signed [EvW-1:0]   ev_q, ev_d;
  logic                    drop_q, drop_d;
  logic [CountW-1:0]       cnt_q, cnt_d;

  logic                    out_valid_q, out_valid_d;
  logic                    status_q;
  logic                    neg_q;
  logic [MantW-1:0]        mant_q;
  logic signed [ExpW-1:0]  eo_q;
  logic                    dropo_q;
  logic [CountW-1:0]       chars_q;

  logic                    out_adv;
  logic                    emit;
  logic                    nonum;
  logic                    quit;
  logic [MantW-1:0]        acc_x10;
  logic signed [19:0]      ev_ext;
  logic signed [19:0]      ev_x10;
  logic signed [19:0]      ev_new;
  logic signed [16:0]      eo_raw;
  logic signed [ExpW-1:0]  eo_sat;

  assign out_adv = ~out_valid_q | ~out_stall_i;
  assign pop_o   = q_not_empty_i & out_adv;

  assign acc_x10 = (acc_q << 3) + (acc_q << 1) + MantW'(head_i.digit);
  assign ev_ext  = 20'(ev_q);
  assign ev_x10  = (ev_ext <<< 3) + (ev_ext <<< 1);
  assign ev_new  = (phase_q == PH_ENEG) ? ev_x10 - 20'(head_i.digit)
                                        : ev_x10 + 20'(head_i.digit);
  assign eo_raw  = 17'(ev_q) - 17'(fc_q);

  always_comb begin
    if (eo_raw > EoMax) begin
      eo_sat = EoMax[ExpW-1:0];
    end else if (eo_raw < EoMin) begin
      eo_sat = EoMin[ExpW-1:0];
    end else begin
      eo_sat = eo_raw[ExpW-1:0];
    end
  end

  always_comb begin
    mode_d  = mode_q;
    pend_d  = pend_q;
    phase_d = phase_q;
    sign_d  = sign_q;
    acc_d   = acc_q;
    sig_d   = sig_q;
    fc_d    = fc_q;
    ev_d    = ev_q;
    drop_d  = drop_q;
    cnt_d   = cnt_q;
    emit    = 1'b0;
    nonum   = 1'b0;
    quit    = 1'b0;
    if (pop_o) begin
      unique case (mode_q)
        MODE_PARSE: begin
          if (head_i.cls == CL_SPACE || head_i.cls == CL_NUL) begin
            emit   = 1'b1;
            mode_d = MODE_SEEK;
          end else begin
            unique case (head_i.cls)
              CL_MINUS: begin
                if (phase_q == PH_INT && acc_q == '0) begin
                  sign_d = 1'b1;
                end else if (phase_q == PH_EPOS && ev_q == '0) begin
                  phase_d = PH_ENEG;
                end else begin
                  quit = 1'b1;
                end
              end
              CL_DOT:  phase_d = PH_FRAC;
              CL_EXP:  phase_d = PH_EPOS;
              CL_PLUS: ;
              CL_DIGIT: begin
                if (phase_q == PH_INT || phase_q == PH_FRAC) begin
                  if (sig_q < SigW'(MAX_DIGITS)) begin
                    acc_d = acc_x10;
                    if (acc_x10 != '0) begin
                      sig_d = sig_q + 1'b1;
                    end
                    if (phase_q == PH_FRAC && fc_q != FcMax) begin
                      fc_d = fc_q + 1'b1;
                    end
                  end else begin
                    drop_d = 1'b1;
                    if (phase_q == PH_INT && fc_q != FcMin) begin
                      fc_d = fc_q - 1'b1;
                    end
                  end
                end else if (ev_new > EvMax) begin
                  ev_d = EvMax[EvW-1:0];
                end else if (ev_new < EvMin) begin
                  ev_d = EvMin[EvW-1:0];
                end else begin
                  ev_d = ev_new[EvW-1:0];
                end
              end
              default: quit = 1'b1;
            endcase
            if (quit) begin
              emit = 1'b1;
              if (head_i.cls == CL_MINUS) begin
                pend_d = head_i.cls;
                mode_d = MODE_PEND;
              end else begin
                mode_d = MODE_SEEK;
              end
            end else if (cnt_q != '1) begin
              cnt_d = cnt_q + 1'b1;
            end
          end
        end
        default: begin
          if (head_i.cls == CL_DIGIT) begin
            mode_d  = MODE_PARSE;
            phase_d = PH_INT;
            sign_d  = 1'b0;
            acc_d   = MantW'(head_i.digit);
            sig_d   = SigW'(head_i.digit != '0);
            fc_d    = '0;
            ev_d    = '0;
            drop_d  = 1'b0;
            cnt_d   = CountW'(1);
            if (mode_q == MODE_PEND) begin
              cnt_d = CountW'(2);
              if (pend_q == CL_DOT) begin
                phase_d = PH_FRAC;
                fc_d    = FcW'(1);
              end else if (pend_q == CL_MINUS) begin
                sign_d = 1'b1;
              end
            end
          end else if (head_i.cls == CL_DOT || head_i.cls == CL_MINUS ||
                       head_i.cls == CL_PLUS) begin
            pend_d = head_i.cls;
            mode_d = MODE_PEND;
          end else begin
            nonum  = (head_i.cls == CL_NUL);
            mode_d = MODE_SEEK;
          end
        end
      endcase
    end
  end

  assign out_valid_d = out_adv ? (emit | nonum) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SEEK;
      pend_q      <= CL_OTHER;
      phase_q     <= PH_INT;
      sign_q      <= 1'b0;
      acc_q       <= '0;
      sig_q       <= '0;
      fc_q        <= '0;
      ev_q        <= '0;
      drop_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      pend_q      <= pend_d;
      phase_q     <= phase_d;
      sign_q      <= sign_d;
      acc_q       <= acc_d;
      sig_q       <= sig_d;
      fc_q        <= fc_d;
      ev_q        <= ev_d;
      drop_q      <= drop_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= 1'b0;
      neg_q    <= sign_q;
      mant_q   <= acc_q;
      eo_q     <= eo_sat;
      dropo_q  <= drop_q;
      chars_q  <= cnt_q;
    end else if (nonum) begin
      status_q <= 1'b1;
      neg_q    <= 1'b0;
      mant_q   <= '0;
      eo_q     <= '0;
      dropo_q  <= 1'b0;
      chars_q  <= '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign is_negative_o      = neg_q;
  assign mantissa_o         = mant_q;
  assign decimal_exponent_o = eo_q;
  assign digits_dropped_o   = dropo_q;
  assign chars_used_o       = chars_q;

endmodule

`default_nettype wire

### hw/rtl/decimal_number_text_parser_core.sv
// Decimal number text parser, top level: front end, byte queue, back end.
// Depends on dntp_pkg, dntp_front, dntp_queue and dntp_back.
//
// Input: one text byte per request on in_valid_i/in_stall_o; NUL ends a string.
// Output: one request per parsed number on out_valid_o/out_stall_i, carrying
// sign, decimal mantissa (up to MAX_DIGITS digits), saturated decimal exponent,
// a dropped-digits flag and the byte count. A NUL seen with no number pending
// gives a request with status 1 and all other fields zero.
// Throughput: one byte per cycle, except while a stalled result is held in
// the output register. The byte ending the number (terminator or quitting
// byte) is written into the queue; the result is registered when it is popped.
// A four-entry queue decouples input from output; when the receiver stalls,
// the result register holds and the queue keeps taking bytes until full,
// then in_stall_o rises. Reset clears the queue and returns the parser to
// seeking with no pending byte and no result.
`default_nettype none

module decimal_number_text_parser_core #(
  parameter int unsigned MAX_DIGITS = 18,
  parameter int unsigned EXP_LIMIT  = 9999
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        text_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              status_o,
  output logic                              is_negative_o,
  output logic [dntp_pkg::MantW-1:0]        mantissa_o,
  output logic signed [dntp_pkg::ExpW-1:0]  decimal_exponent_o,
  output logic                              digits_dropped_o,
  output logic [dntp_pkg::CountW-1:0]       chars_used_o
);
  import dntp_pkg::*;

  logic   q_full;
  logic   q_not_empty;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head;

  dntp_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  dntp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .full_o       (q_full),
    .not_empty_o  (q_not_empty),
    .head_o       (head)
  );

  dntp_back #(
    .MAX_DIGITS (MAX_DIGITS),
    .EXP_LIMIT  (EXP_LIMIT)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_not_empty_i      (q_not_empty),
    .head_i             (head),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .is_negative_o      (is_negative_o),
    .mantissa_o         (mantissa_o),
    .decimal_exponent_o (decimal_exponent_o),
    .digits_dropped_o   (digits_dropped_o),
    .chars_used_o       (chars_used_o)
  );

endmodule

`default_nettype wire
